FILE: rtl/core/fva_pkg.sv
// ============================================================================
// fva_pkg: shared types and constants for the FLV video to Annex B converter
// Command word passed from the tag parser to the output expander, status
// codes and the fixed values of the FLV container format.
// ============================================================================
`default_nettype none

package fva_pkg;

    // Status codes carried on output words
    localparam logic [1:0] ST_DATA    = 2'd0;
    localparam logic [1:0] ST_BADSIG  = 2'd1;
    localparam logic [1:0] ST_OVERRUN = 2'd2;
    localparam logic [1:0] ST_ENDED   = 2'd3;

    // FLV format constants
    localparam logic [23:0] SIG_UPPER  = 24'h464C56;   // "FLV"
    localparam logic [23:0] SIG_LOWER  = 24'h666C76;   // "flv"
    localparam logic [7:0]  VIDEO_KIND = 8'd9;
    localparam logic [31:0] MIN_HEAD   = 32'd9;

    // Final byte of the 00 00 00 01 start code
    localparam logic [7:0]  START_TAIL = 8'h01;
    localparam int unsigned START_WORDS = 4;

    // Default depth of the command queue
    localparam int unsigned QUEUE_DEPTH = 4;

    // Main action of one input byte
    typedef enum logic [1:0] {
        MAIN_NONE,
        MAIN_DATA,
        MAIN_START,
        MAIN_SIG
    } t_main;

    // One queued command: what one input byte makes the output emit
    typedef struct packed {
        t_main      main;
        logic [7:0] data;
        logic       over;
        logic       end_flag;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/core/fva_front.sv
// ============================================================================
// fva_front: FLV tag parser
// Walks the FLV file header and tags one byte per cycle unless the queue is
// full and turns every byte into at most one command for the output expander.
// ============================================================================
`default_nettype none

module fva_front
    import fva_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_end,
    input  wire logic       i_full,
    output t_cmd            o_cmd,
    output logic            o_push
);

    typedef enum logic [4:0] {
        PH_HEAD, PH_HSKIP, PH_PREV, PH_TYPE, PH_SIZE, PH_TIME, PH_SID, PH_SKIPTAG,
        PH_VINFO, PH_VAVC, PH_VCTS, PH_SSKIP, PH_SLEN, PH_SDATA, PH_PNUM, PH_PLEN,
        PH_PDATA, PH_NLEN, PH_NDATA
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_idx, n_idx;
    logic [31:0] r_fv, n_fv;
    logic [31:0] r_hskip, n_hskip;
    logic [31:0] r_pos, n_pos;
    logic [7:0]  r_kind, n_kind;
    logic [23:0] r_tag_left, n_tag_left;
    logic [7:0]  r_avc, n_avc;
    logic [23:0] r_nal_left, n_nal_left;
    logic        r_rej, n_rej;

    logic        accept;
    logic [31:0] acc_fv;
    logic [2:0]  acc_idx;
    logic [31:0] head_fv;
    logic [31:0] head_len;
    logic [23:0] tl;
    logic        over;
    logic [23:0] nl_start;
    logic [23:0] nl_dec;

    assign accept = i_valid && !i_full;

    // Shift the next byte into the field value
    assign acc_fv  = {r_fv[23:0], i_in_byte};
    assign acc_idx = r_idx + 3'd1;

    // File header: signature bytes, version clears the field, flags skipped, length
    assign head_fv  = (r_pos == 32'd3) ? '0 :
                      (r_pos == 32'd4) ? r_fv : {r_fv[23:0], i_in_byte};
    assign head_len = (head_fv < MIN_HEAD) ? MIN_HEAD : head_fv;

    // Tag body bookkeeping and unit length clipping
    assign tl       = r_tag_left - 24'd1;
    assign over     = acc_fv > {8'd0, tl};
    assign nl_start = over ? tl : acc_fv[23:0];
    assign nl_dec   = r_nal_left - 24'd1;

    // Parse one byte
    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_fv       = r_fv;
        n_hskip    = r_hskip;
        n_pos      = r_pos;
        n_kind     = r_kind;
        n_tag_left = r_tag_left;
        n_avc      = r_avc;
        n_nal_left = r_nal_left;
        n_rej      = r_rej;
        o_cmd.main     = MAIN_NONE;
        o_cmd.data     = i_in_byte;
        o_cmd.over     = 1'b0;
        o_cmd.end_flag = 1'b0;
        o_push         = 1'b0;
        if (accept) begin
            if (!r_rej) begin
                case (r_phase)
                    PH_HEAD: begin
                        n_fv = head_fv;
                        if (r_pos == 32'd2) begin
                            if (head_fv[23:0] != SIG_UPPER && head_fv[23:0] != SIG_LOWER) begin
                                n_rej      = 1'b1;
                                o_cmd.main = MAIN_SIG;
                            end
                        end
                        if (r_pos == 32'd8) begin
                            n_hskip = head_len;
                            n_pos   = MIN_HEAD;
                            n_phase = (head_len > MIN_HEAD) ? PH_HSKIP : PH_PREV;
                            n_idx   = '0;
                            n_fv    = '0;
                        end else begin
                            n_pos = r_pos + 32'd1;
                        end
                    end
                    PH_HSKIP: begin
                        n_pos = r_pos + 32'd1;
                        if (n_pos == r_hskip) begin
                            n_phase = PH_PREV;
                            n_idx   = '0;
                            n_fv    = '0;
                        end
                    end
                    PH_PREV: begin
                        n_idx = acc_idx;
                        if (acc_idx == 3'd4) begin
                            n_phase = PH_TYPE;
                            n_idx   = '0;
                            n_fv    = '0;
                        end
                    end
                    PH_TYPE: begin
                        n_kind  = i_in_byte;
                        n_phase = PH_SIZE;
                        n_idx   = '0;
                        n_fv    = '0;
                    end
                    PH_SIZE: begin
                        n_fv  = acc_fv;
                        n_idx = acc_idx;
                        if (acc_idx == 3'd3) begin
                            n_tag_left = acc_fv[23:0];
                            n_phase    = PH_TIME;
                            n_idx      = '0;
                            n_fv       = '0;
                        end
                    end
                    PH_TIME: begin
                        n_idx = acc_idx;
                        if (acc_idx == 3'd4) begin
                            n_phase = PH_SID;
                            n_idx   = '0;
                            n_fv    = '0;
                        end
                    end
                    PH_SID: begin
                        n_idx = acc_idx;
                        if (acc_idx == 3'd3) begin
                            n_idx = '0;
                            n_fv  = '0;
                            if (r_tag_left == '0) begin
                                n_phase = PH_PREV;
                            end else if (r_kind == VIDEO_KIND) begin
                                n_phase = PH_VINFO;
                            end else begin
                                n_phase = PH_SKIPTAG;
                            end
                        end
                    end
                    default: begin
                        // Tag body: one byte less left in the tag
                        n_tag_left = tl;
                        case (r_phase)
                            PH_VINFO: begin
                                n_phase = PH_VAVC;
                                n_idx   = '0;
                                n_fv    = '0;
                            end
                            PH_VAVC: begin
                                n_avc   = i_in_byte;
                                n_phase = PH_VCTS;
                                n_idx   = '0;
                                n_fv    = '0;
                            end
                            PH_VCTS: begin
                                n_idx = acc_idx;
                                if (acc_idx == 3'd3) begin
                                    n_phase = (r_avc == 8'd0) ? PH_SSKIP : PH_NLEN;
                                    n_idx   = '0;
                                    n_fv    = '0;
                                end
                            end
                            PH_SSKIP: begin
                                n_idx = acc_idx;
                                if (acc_idx == 3'd6) begin
                                    n_phase = PH_SLEN;
                                    n_idx   = '0;
                                    n_fv    = '0;
                                end
                            end
                            PH_SLEN: begin
                                n_fv  = acc_fv;
                                n_idx = acc_idx;
                                if (acc_idx == 3'd2) begin
                                    n_nal_left = nl_start;
                                    o_cmd.main = MAIN_START;
                                    o_cmd.over = over;
                                    n_phase    = (nl_start == '0) ? PH_PNUM : PH_SDATA;
                                    n_idx      = '0;
                                    n_fv       = '0;
                                end
                            end
                            PH_SDATA: begin
                                o_cmd.main = MAIN_DATA;
                                n_nal_left = nl_dec;
                                if (nl_dec == '0) begin
                                    n_phase = PH_PNUM;
                                    n_idx   = '0;
                                    n_fv    = '0;
                                end
                            end
                            PH_PNUM: begin
                                n_phase = PH_PLEN;
                                n_idx   = '0;
                                n_fv    = '0;
                            end
                            PH_PLEN: begin
                                n_fv  = acc_fv;
                                n_idx = acc_idx;
                                if (acc_idx == 3'd2) begin
                                    n_nal_left = nl_start;
                                    o_cmd.main = MAIN_START;
                                    o_cmd.over = over;
                                    n_phase    = (nl_start == '0) ? PH_SKIPTAG : PH_PDATA;
                                    n_idx      = '0;
                                    n_fv       = '0;
                                end
                            end
                            PH_PDATA: begin
                                o_cmd.main = MAIN_DATA;
                                n_nal_left = nl_dec;
                                if (nl_dec == '0) begin
                                    n_phase = PH_SKIPTAG;
                                    n_idx   = '0;
                                    n_fv    = '0;
                                end
                            end
                            PH_NLEN: begin
                                n_fv  = acc_fv;
                                n_idx = acc_idx;
                                if (acc_idx == 3'd4) begin
                                    n_nal_left = nl_start;
                                    o_cmd.main = MAIN_START;
                                    o_cmd.over = over;
                                    n_phase    = (nl_start == '0) ? PH_NLEN : PH_NDATA;
                                    n_idx      = '0;
                                    n_fv       = '0;
                                end
                            end
                            PH_NDATA: begin
                                o_cmd.main = MAIN_DATA;
                                n_nal_left = nl_dec;
                                if (nl_dec == '0) begin
                                    n_phase = PH_NLEN;
                                    n_idx   = '0;
                                    n_fv    = '0;
                                end
                            end
                            default: begin
                            end
                        endcase
                        // Tag end: return to the previous tag size field before the next tag
                        if (tl == '0) begin
                            n_phase = PH_PREV;
                            n_idx   = '0;
                            n_fv    = '0;
                        end
                    end
                endcase
            end
            // End of file: flag a cut inside the header fields or a tag, then restart
            if (i_in_end) begin
                if (!n_rej && !(n_phase inside {PH_HSKIP, PH_PREV, PH_TYPE})) begin
                    o_cmd.end_flag = 1'b1;
                end
                n_phase    = PH_HEAD;
                n_idx      = '0;
                n_fv       = '0;
                n_hskip    = '0;
                n_pos      = '0;
                n_kind     = '0;
                n_tag_left = '0;
                n_avc      = '0;
                n_nal_left = '0;
                n_rej      = 1'b0;
            end
            o_push = (o_cmd.main != MAIN_NONE) || o_cmd.end_flag;
        end
    end

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEAD;
            r_idx      <= '0;
            r_fv       <= '0;
            r_hskip    <= '0;
            r_pos      <= '0;
            r_kind     <= '0;
            r_tag_left <= '0;
            r_avc      <= '0;
            r_nal_left <= '0;
            r_rej      <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_fv       <= n_fv;
            r_hskip    <= n_hskip;
            r_pos      <= n_pos;
            r_kind     <= n_kind;
            r_tag_left <= n_tag_left;
            r_avc      <= n_avc;
            r_nal_left <= n_nal_left;
            r_rej      <= n_rej;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/fva_queue.sv
// ============================================================================
// fva_queue: command queue
// Small first-in first-out store that decouples the parser from the output
// expander so that start codes do not stall the input on every unit.
// ============================================================================
`default_nettype none

module fva_queue
    import fva_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output logic      o_empty,
    output logic      o_full
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers with wrap
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Store pushed word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/fva_back.sv
// ============================================================================
// fva_back: output expander
// Expands each queued command into its output words (start code, data byte
// or status) and holds them in an output register under the stall handshake.
// ============================================================================
`default_nettype none

module fva_back
    import fva_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  t_cmd            i_head,
    input  wire logic       i_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_nal_start,
    output logic            o_run_last,
    output logic [1:0]      o_status
);

    logic [2:0] r_sub, n_sub;
    logic       r_valid, n_valid;
    logic [7:0] r_byte;
    logic       r_start;
    logic       r_last;
    logic [1:0] r_status;

    logic [2:0] main_words;
    logic [2:0] total_words;
    logic       load;
    logic       w_last;
    logic [7:0] w_byte;
    logic       w_start;
    logic [1:0] w_status;

    // Count the words of the head command
    always_comb begin
        case (i_head.main)
            MAIN_DATA:  main_words = 3'd1;
            MAIN_SIG:   main_words = 3'd1;
            MAIN_START: main_words = 3'(START_WORDS);
            default:    main_words = 3'd0;
        endcase
    end

    assign total_words = main_words + {2'd0, i_head.end_flag};
    assign w_last      = (r_sub == total_words - 3'd1);
    assign load        = !i_empty && (!r_valid || !i_stall);
    assign o_pop       = load && w_last;

    // Select the word at the current position
    always_comb begin
        w_byte   = 8'd0;
        w_start  = 1'b0;
        w_status = ST_ENDED;
        if (r_sub < main_words) begin
            case (i_head.main)
                MAIN_START: begin
                    w_byte   = (r_sub == 3'(START_WORDS - 1)) ? START_TAIL : 8'd0;
                    w_start  = (r_sub == 3'd0);
                    w_status = (r_sub == 3'd0 && i_head.over) ? ST_OVERRUN : ST_DATA;
                end
                MAIN_DATA: begin
                    w_byte   = i_head.data;
                    w_status = ST_DATA;
                end
                MAIN_SIG: begin
                    w_status = ST_BADSIG;
                end
                default: begin
                end
            endcase
        end
    end

    // Advance within the command, drop the output word once taken
    always_comb begin
        n_sub   = r_sub;
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
            n_sub   = w_last ? 3'd0 : r_sub + 3'd1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_sub   <= n_sub;
            r_valid <= n_valid;
        end
    end

    // Hold output word
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte   <= w_byte;
            r_start  <= w_start;
            r_last   <= w_last;
            r_status <= w_status;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_byte  = r_byte;
    assign o_nal_start = r_start;
    assign o_run_last  = r_last;
    assign o_status    = r_status;

endmodule

`default_nettype wire

FILE: rtl/core/flv_video_to_annexb_core.sv
// ============================================================================
// flv_video_to_annexb_core: FLV video tags to H.264 Annex B converter
// Parses an FLV byte stream and emits the H.264 NAL units of its video tags,
// each behind a 00 00 00 01 start code, with status words for errors.
// ============================================================================
// The block takes one FLV file byte per cycle on the input channel; the
// parser turns each byte combinationally into at most one command, which
// waits in a queue of QUEUE_DEPTH_P entries until the output expander
// sends its words, one per cycle unless the output stalls: a data or status
// byte is one word, a NAL unit start is four, and an end-of-file status adds
// one more. Input stalls only while the queue is full, so sustained
// throughput is one byte per cycle except where start codes or output stalls
// fill the queue. Results pass through the queue and the output register.
`default_nettype none

module flv_video_to_annexb_core
    import fva_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_end,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_nal_start,
    output logic            o_run_last,
    output logic [1:0]      o_status
);

    t_cmd cmd;
    t_cmd head;
    logic push;
    logic pop;
    logic empty;
    logic full;

    assign o_stall = full;

    fva_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_in_byte (i_in_byte),
        .i_in_end  (i_in_end),
        .i_full    (full),
        .o_cmd     (cmd),
        .o_push    (push)
    );

    fva_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    fva_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_nal_start (o_nal_start),
        .o_run_last  (o_run_last),
        .o_status    (o_status)
    );

endmodule

`default_nettype wire

FILE: dv/flv_annexb_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// flv_annexb_checker: scoreboard for the FLV to Annex B converter
// Watches both channels, keeps its own copy of the parser state, predicts
// the words each accepted FLV byte produces and compares them in order.
// ============================================================================

module flv_annexb_checker
    import fva_pkg::*;
#(
    parameter logic [7:0] AVC_SEQ_HEADER = 8'd0
)
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_end,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire logic [7:0] i_out_byte,
    input  wire logic       i_nal_start,
    input  wire logic       i_run_last,
    input  wire logic [1:0] i_status,
    output int              o_fail_count,
    output int              o_pending
);

    localparam int MAX_RUN = 5;

    // Byte offsets inside the FLV file header
    localparam logic [31:0] HDR_SIG_LAST = 32'd2;
    localparam logic [31:0] HDR_VERSION  = 32'd3;
    localparam logic [31:0] HDR_FLAGS    = 32'd4;
    localparam logic [31:0] HDR_LEN_LAST = 32'd8;

    typedef enum logic [4:0] {
        P_HEAD, P_HSKIP, P_PREV, P_TYPE, P_SIZE, P_TIME, P_SID, P_SKIPTAG,
        P_VINFO, P_VAVC, P_VCTS, P_SSKIP, P_SLEN, P_SDATA, P_PNUM, P_PLEN,
        P_PDATA, P_NLEN, P_NDATA
    } t_parse_phase;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       nal_start;
        logic       run_last;
        logic [1:0] status;
    } t_annexb_word;

    t_parse_phase parse_phase;
    logic [2:0]   field_idx;
    logic [31:0]  field_acc;
    logic [31:0]  head_end;
    logic [31:0]  file_pos;
    logic [7:0]   tag_type;
    logic [23:0]  tag_remaining;
    logic [7:0]   avc_type;
    logic [31:0]  unit_remaining;
    logic         sig_rejected;

    t_annexb_word byte_words[$];
    t_annexb_word expected_words[$];
    int           fail_total = 0;

    function automatic void clear_state();
        parse_phase    = P_HEAD;
        field_idx      = '0;
        field_acc      = '0;
        head_end       = '0;
        file_pos       = '0;
        tag_type       = '0;
        tag_remaining  = '0;
        avc_type       = '0;
        unit_remaining = '0;
        sig_rejected   = 1'b0;
    endfunction

    function automatic void enter_phase(t_parse_phase p);
        parse_phase = p;
        field_idx   = '0;
        field_acc   = '0;
    endfunction

    function automatic void shift_field(logic [7:0] b);
        field_acc = {field_acc[23:0], b};
        field_idx = field_idx + 3'd1;
    endfunction

    // Drop anything beyond the per-byte word limit
    function automatic void emit_word(logic [7:0] v, logic first, logic [1:0] st);
        if (byte_words.size() < MAX_RUN) begin
            byte_words.push_back('{out_byte: v, nal_start: first, run_last: 1'b0,
                                   status: st});
        end
    endfunction

    // Start code for a unit; cut the length at the tag end. Returns 1 if empty.
    function automatic logic open_unit(logic [31:0] len);
        logic over;
        over = len > {8'd0, tag_remaining};
        unit_remaining = over ? {8'd0, tag_remaining} : len;
        emit_word(8'h00, 1'b1, over ? ST_OVERRUN : ST_DATA);
        emit_word(8'h00, 1'b0, ST_DATA);
        emit_word(8'h00, 1'b0, ST_DATA);
        emit_word(START_TAIL, 1'b0, ST_DATA);
        return unit_remaining == 0;
    endfunction

    function automatic void unit_byte(logic [7:0] b, t_parse_phase after);
        emit_word(b, 1'b0, ST_DATA);
        unit_remaining = unit_remaining - 32'd1;
        if (unit_remaining == 0) begin
            enter_phase(after);
        end
    endfunction

    // One byte inside a tag body
    function automatic void tag_body_byte(logic [7:0] b);
        logic [31:0] len;
        tag_remaining = tag_remaining - 24'd1;
        case (parse_phase)
            P_VINFO: enter_phase(P_VAVC);
            P_VAVC: begin
                avc_type = b;
                enter_phase(P_VCTS);
            end
            P_VCTS: begin
                field_idx = field_idx + 3'd1;
                if (field_idx == 3'd3) begin
                    if (avc_type == AVC_SEQ_HEADER) begin
                        enter_phase(P_SSKIP);
                    end else begin
                        enter_phase(P_NLEN);
                    end
                end
            end
            P_SSKIP: begin
                field_idx = field_idx + 3'd1;
                if (field_idx == 3'd6) begin
                    enter_phase(P_SLEN);
                end
            end
            P_SLEN: begin
                shift_field(b);
                if (field_idx == 3'd2) begin
                    len = field_acc;
                    enter_phase(P_SDATA);
                    if (open_unit(len)) begin
                        enter_phase(P_PNUM);
                    end
                end
            end
            P_SDATA: unit_byte(b, P_PNUM);
            P_PNUM: enter_phase(P_PLEN);
            P_PLEN: begin
                shift_field(b);
                if (field_idx == 3'd2) begin
                    len = field_acc;
                    enter_phase(P_PDATA);
                    if (open_unit(len)) begin
                        enter_phase(P_SKIPTAG);
                    end
                end
            end
            P_PDATA: unit_byte(b, P_SKIPTAG);
            P_NLEN: begin
                shift_field(b);
                if (field_idx == 3'd4) begin
                    len = field_acc;
                    enter_phase(P_NDATA);
                    if (open_unit(len)) begin
                        enter_phase(P_NLEN);
                    end
                end
            end
            P_NDATA: unit_byte(b, P_NLEN);
            default: ;
        endcase
        if (tag_remaining == 0) begin
            enter_phase(P_PREV);
        end
    endfunction

    // Predict the words of one accepted file byte and queue them
    function automatic void predict_byte(logic [7:0] b, logic fin);
        byte_words.delete();
        if (!sig_rejected) begin
            case (parse_phase)
                P_HEAD: begin
                    if (file_pos == HDR_VERSION) begin
                        field_acc = '0;
                    end else if (file_pos != HDR_FLAGS) begin
                        field_acc = {field_acc[23:0], b};
                    end
                    if (file_pos == HDR_SIG_LAST && field_acc[23:0] != SIG_UPPER
                            && field_acc[23:0] != SIG_LOWER) begin
                        sig_rejected = 1'b1;
                        emit_word(8'h00, 1'b0, ST_BADSIG);
                    end
                    if (file_pos == HDR_LEN_LAST) begin
                        head_end = (field_acc < MIN_HEAD) ? MIN_HEAD : field_acc;
                        file_pos = MIN_HEAD;
                        if (head_end > MIN_HEAD) begin
                            enter_phase(P_HSKIP);
                        end else begin
                            enter_phase(P_PREV);
                        end
                    end else begin
                        file_pos = file_pos + 32'd1;
                    end
                end
                P_HSKIP: begin
                    file_pos = file_pos + 32'd1;
                    if (file_pos == head_end) begin
                        enter_phase(P_PREV);
                    end
                end
                P_PREV: begin
                    field_idx = field_idx + 3'd1;
                    if (field_idx == 3'd4) begin
                        enter_phase(P_TYPE);
                    end
                end
                P_TYPE: begin
                    tag_type = b;
                    enter_phase(P_SIZE);
                end
                P_SIZE: begin
                    shift_field(b);
                    if (field_idx == 3'd3) begin
                        tag_remaining = field_acc[23:0];
                        enter_phase(P_TIME);
                    end
                end
                P_TIME: begin
                    field_idx = field_idx + 3'd1;
                    if (field_idx == 3'd4) begin
                        enter_phase(P_SID);
                    end
                end
                P_SID: begin
                    field_idx = field_idx + 3'd1;
                    if (field_idx == 3'd3) begin
                        if (tag_remaining == 0) begin
                            enter_phase(P_PREV);
                        end else if (tag_type == VIDEO_KIND) begin
                            enter_phase(P_VINFO);
                        end else begin
                            enter_phase(P_SKIPTAG);
                        end
                    end
                end
                default: tag_body_byte(b);
            endcase
        end
        // Flag a file that stops inside the header fields or a tag
        if (fin) begin
            if (!sig_rejected && parse_phase != P_HSKIP && parse_phase != P_PREV
                    && parse_phase != P_TYPE) begin
                emit_word(8'h00, 1'b0, ST_ENDED);
            end
            clear_state();
        end
        if (byte_words.size() > 0) begin
            byte_words[byte_words.size() - 1].run_last = 1'b1;
        end
        foreach (byte_words[i]) begin
            expected_words.push_back(byte_words[i]);
        end
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_total++;
        end
    endfunction

    function automatic void check_word();
        t_annexb_word want;
        if (expected_words.size() == 0) begin
            $error("unexpected word: out_byte %0h nal_start %0b run_last %0b status %0d",
                   i_out_byte, i_nal_start, i_run_last, i_status);
            fail_total++;
        end else begin
            want = expected_words.pop_front();
            check_field("out_byte", want.out_byte, i_out_byte);
            check_field("nal_start", {7'd0, want.nal_start}, {7'd0, i_nal_start});
            check_field("run_last", {7'd0, want.run_last}, {7'd0, i_run_last});
            check_field("status", {6'd0, want.status}, {6'd0, i_status});
        end
    endfunction

    // Predict on input handshakes, compare on output handshakes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            expected_words.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predict_byte(i_in_byte, i_in_end);
            end
            if (i_out_valid && !i_out_stall) begin
                check_word();
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_words.size();
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top: testbench for flv_video_to_annexb_core
// Feeds hand-built and randomly generated FLV files into the converter with
// random gaps and output stalls; the checker predicts and compares.
// ============================================================================

module tb_top;
    import fva_pkg::*;

    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          RANDOM_BYTES   = 150;
    localparam int          DRAIN_CYCLES   = 20;
    localparam logic [7:0]  AVC_SEQ_HEADER = 8'd0;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_end  = 1'b0;
    logic       i_stall   = 1'b0;

    wire logic       o_stall;
    wire logic       o_valid;
    wire logic [7:0] o_out_byte;
    wire logic       o_nal_start;
    wire logic       o_run_last;
    wire logic [1:0] o_status;

    int fail_count;
    int pending_count;
    int tx_idle_pct = 12;
    int rx_idle_pct = 58;
    int cycle_count = 0;
    int bytes_sent  = 0;

    logic [7:0] flv_file[$];
    logic [7:0] tag_body[$];

    flv_video_to_annexb_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_byte   (i_in_byte),
        .i_in_end    (i_in_end),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_nal_start (o_nal_start),
        .o_run_last  (o_run_last),
        .o_status    (o_status)
    );

    flv_annexb_checker #(
        .AVC_SEQ_HEADER (AVC_SEQ_HEADER)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_byte    (i_in_byte),
        .i_in_end     (i_in_end),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_byte   (o_out_byte),
        .i_nal_start  (o_nal_start),
        .i_run_last   (o_run_last),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always #5 i_clk = ~i_clk;

    // Random output backpressure
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("flv_video_to_annexb_core test failed");
            $finish;
        end
    end

    // Append n bytes of v, most significant first, to the file or tag body
    task automatic push_be(input logic [31:0] v, input int n, input bit into_body);
        for (int k = n - 1; k >= 0; k--) begin
            if (into_body) begin
                tag_body.push_back(v[8 * k +: 8]);
            end else begin
                flv_file.push_back(v[8 * k +: 8]);
            end
        end
    endtask

    // Offer one byte; hold it until the converter takes it
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_in_end  <= fin;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic send_file();
        foreach (flv_file[i]) begin
            send_byte(flv_file[i], i == flv_file.size() - 1);
        end
        bytes_sent += flv_file.size();
    endtask

    // Hold the input idle until every predicted word has come out
    task automatic drain();
        i_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending_count != 0);
    endtask

    // Length prefix plus data; sometimes a length far past the tag end
    task automatic add_unit(input int len_bytes);
        logic [31:0] len;
        int          n_data;
        if ($urandom_range(4) != 0) begin
            len = $urandom_range(10, 0);
        end else begin
            len = $urandom & ((len_bytes == 2) ? 32'h0000FFFF : 32'hFFFFFFFF);
        end
        n_data = (len <= 10) ? int'(len) : $urandom_range(6, 0);
        push_be(len, len_bytes, 1'b1);
        repeat (n_data) push_be($urandom, 1, 1'b1);
    endtask

    task automatic build_video_body(input bit seq_hdr);
        push_be($urandom, 1, 1'b1);
        if (seq_hdr) begin
            push_be(32'(AVC_SEQ_HEADER), 1, 1'b1);
        end else begin
            push_be(($urandom_range(3) == 0) ? $urandom_range(255, 1) : 1, 1, 1'b1);
        end
        push_be($urandom, 3, 1'b1);
        if (seq_hdr) begin
            // decoder config preamble, SPS, PPS count, PPS, leftovers
            push_be($urandom, 3, 1'b1);
            push_be($urandom, 3, 1'b1);
            add_unit(2);
            push_be($urandom, 1, 1'b1);
            add_unit(2);
            repeat ($urandom_range(3, 0)) push_be($urandom, 1, 1'b1);
        end else begin
            repeat ($urandom_range(3, 0)) add_unit(4);
        end
    endtask

    // Wrap tag_body in a tag; sometimes cut the body short
    task automatic finish_tag(input logic [7:0] kind);
        int size;
        size = tag_body.size();
        if ($urandom_range(7) == 0) begin
            size = $urandom_range(size, 0);
            while (tag_body.size() > size) begin
                void'(tag_body.pop_back());
            end
        end
        push_be($urandom, 4, 1'b0);
        push_be(32'(kind), 1, 1'b0);
        push_be(size, 3, 1'b0);
        push_be($urandom, 4, 1'b0);
        push_be($urandom, 3, 1'b0);
        foreach (tag_body[i]) begin
            flv_file.push_back(tag_body[i]);
        end
    endtask

    task automatic make_random_file();
        int         pick;
        int         hlen;
        int         cut;
        logic [7:0] kind;
        flv_file.delete();
        pick = $urandom_range(19);
        if (pick < 9) begin
            push_be(32'(SIG_UPPER), 3, 1'b0);
        end else if (pick < 18) begin
            push_be(32'(SIG_LOWER), 3, 1'b0);
        end else begin
            push_be($urandom, 3, 1'b0);
        end
        push_be($urandom, 2, 1'b0);
        pick = $urandom_range(9);
        if (pick < 7) begin
            hlen = 9;
        end else if (pick < 8) begin
            hlen = $urandom_range(8, 0);
        end else begin
            hlen = $urandom_range(14, 10);
        end
        push_be(hlen, 4, 1'b0);
        if (hlen > 9) begin
            repeat (hlen - 9) push_be($urandom, 1, 1'b0);
        end
        repeat ($urandom_range(4, 1)) begin
            pick = $urandom_range(9);
            tag_body.delete();
            if (pick <= 5) begin
                build_video_body(pick >= 4);
                finish_tag(VIDEO_KIND);
            end else if (pick <= 7) begin
                do begin
                    kind = 8'($urandom_range(255));
                end while (kind == VIDEO_KIND);
                repeat ($urandom_range(8, 0)) push_be($urandom, 1, 1'b1);
                finish_tag(kind);
            end else if (pick == 8) begin
                finish_tag(8'($urandom));
            end else begin
                // video tag shorter than its preamble
                repeat ($urandom_range(4, 0)) push_be($urandom, 1, 1'b1);
                finish_tag(VIDEO_KIND);
            end
        end
        if ($urandom_range(1) == 1) begin
            push_be($urandom, 4, 1'b0);
        end
        // End the file early now and then
        if ($urandom_range(4) == 0) begin
            cut = $urandom_range(flv_file.size(), 1);
            while (flv_file.size() > cut) begin
                void'(flv_file.pop_back());
            end
        end
    endtask

    initial begin
        int start_bytes;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // One-byte file, ends inside the header
        flv_file = '{8'hFF};
        send_file();
        // Bad signature, later bytes ignored
        flv_file = '{8'h46, 8'h4C, 8'h58, 8'h00};
        send_file();
        // Huge header length, file ends in the skip region
        flv_file = '{8'h66, 8'h6C, 8'h76, 8'h01, 8'h05, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'h00, 8'h80};
        send_file();
        // Short header length; sequence header with empty PPS; overrunning
        // NAL; short video tag; file ends right after a length prefix
        flv_file = '{
            8'h46, 8'h4C, 8'h56, 8'h01, 8'h05, 8'h00, 8'h00, 8'h00, 8'h03,
            8'h00, 8'h00, 8'h00, 8'h00, 8'h09, 8'h00, 8'h00, 8'h12,
            8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h17, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h64, 8'h00, 8'h1F, 8'hFF,
            8'hE1, 8'h00, 8'h02, 8'h67, 8'hFF, 8'h01, 8'h00, 8'h00,
            8'h00, 8'h00, 8'h00, 8'h1D, 8'h09, 8'h00, 8'h00, 8'h10,
            8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h27, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65,
            8'h00, 8'h00, 8'h00, 8'h09, 8'h88, 8'h99,
            8'h00, 8'h00, 8'h00, 8'h1B, 8'h09, 8'h00, 8'h00, 8'h02,
            8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h17, 8'h00,
            8'h00, 8'h00, 8'h00, 8'h0D, 8'h09, 8'h00, 8'h00, 8'h20,
            8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h27, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03
        };
        send_file();
        drain();

        // Random files; swap the idle mix by thirds, last third without gaps
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            case ((bytes_sent - start_bytes) * 3 / RANDOM_BYTES)
                0: begin
                    tx_idle_pct = 12;
                    rx_idle_pct = 58;
                end
                1: begin
                    tx_idle_pct = 58;
                    rx_idle_pct = 12;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            make_random_file();
            send_file();
        end
        drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("flv_video_to_annexb_core test passed");
        end else begin
            $display("flv_video_to_annexb_core test failed");
        end
        $finish;
    end

endmodule
